// ===== sv/complex_arith_unit_defines.svh =====
// Assertion macros for the checker file.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Clocked assertion, ignored while reset is held.
`define CAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/cau_pkg.sv =====
`default_nettype none
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg_re;
        logic neg_im;
        logic dz;
        logic pov_re;
        logic pov_im;
        logic ovf_pass;
    } t_ctl;

endpackage
`default_nettype wire

// ===== sv/cau_div_cell.sv =====
`default_nettype none
module cau_div_cell import cau_pkg::*; #(
    parameter int W     = 32,
    parameter int CW    = 98,
    parameter int QW    = 33,
    parameter int SHIFT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_ctl          i_ctl,
    input  wire logic [CW-1:0] i_rem_re,
    input  wire logic [CW-1:0] i_rem_im,
    input  wire logic [CW-1:0] i_den,
    input  wire logic [QW-1:0] i_q_re,
    input  wire logic [QW-1:0] i_q_im,
    input  wire logic [W-1:0]  i_pass_re,
    input  wire logic [W-1:0]  i_pass_im,
    output t_ctl               o_ctl,
    output logic [CW-1:0]      o_rem_re,
    output logic [CW-1:0]      o_rem_im,
    output logic [CW-1:0]      o_den,
    output logic [QW-1:0]      o_q_re,
    output logic [QW-1:0]      o_q_im,
    output logic [W-1:0]       o_pass_re,
    output logic [W-1:0]       o_pass_im
);

    logic [CW-1:0] dsh;
    logic          ge_re, ge_im;
    t_ctl          r_ctl;
    logic [CW-1:0] r_rem_re, r_rem_im, r_den;
    logic [QW-1:0] r_q_re, r_q_im;
    logic [W-1:0]  r_pass_re, r_pass_im;
    logic [CW-1:0] n_rem_re, n_rem_im;
    logic [QW-1:0] n_q_re, n_q_im;

    // Trial subtract of the shifted divisor, one quotient bit per part
    always_comb begin
        dsh      = i_den << SHIFT;
        ge_re    = (i_rem_re >= dsh);
        ge_im    = (i_rem_im >= dsh);
        n_rem_re = ge_re ? (i_rem_re - dsh) : i_rem_re;
        n_rem_im = ge_im ? (i_rem_im - dsh) : i_rem_im;
        n_q_re   = i_q_re | (QW'(ge_re) << SHIFT);
        n_q_im   = i_q_im | (QW'(ge_im) << SHIFT);
    end

    // Advance the beat to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem_re  <= n_rem_re;
        r_rem_im  <= n_rem_im;
        r_den     <= i_den;
        r_q_re    <= n_q_re;
        r_q_im    <= n_q_im;
        r_pass_re <= i_pass_re;
        r_pass_im <= i_pass_im;
    end

    assign o_ctl     = r_ctl;
    assign o_rem_re  = r_rem_re;
    assign o_rem_im  = r_rem_im;
    assign o_den     = r_den;
    assign o_q_re    = r_q_re;
    assign o_q_im    = r_q_im;
    assign o_pass_re = r_pass_re;
    assign o_pass_im = r_pass_im;

endmodule
`default_nettype wire

// ===== sv/complex_arith_unit.sv =====
// Path from start to o_strobe: stage 1, stage 2, the divider cells (33 at the default width), output register.
// Throughput: one beat per cycle for every opcode; busy stays low.
// The divide runs through a row of DATA_WIDTH+1 restoring cells, one quotient bit per cell,
// and all opcodes follow the same path so results leave in order.
// The receiver cannot stall: each result shows for one cycle with o_strobe.
// Reset (i_rst_n low, synchronous) drops all beats in flight; payload is not cleared.
`default_nettype none
module complex_arith_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_req_type,
    input  wire logic signed [DATA_WIDTH-1:0] i_a_real,
    input  wire logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  wire logic signed [DATA_WIDTH-1:0] i_b_real,
    input  wire logic signed [DATA_WIDTH-1:0] i_b_imag,
    output logic                              o_strobe,
    output logic signed [DATA_WIDTH-1:0]      o_res_real,
    output logic signed [DATA_WIDTH-1:0]      o_res_imag,
    output logic                              o_overflow,
    output logic                              o_div_zero
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 1;
    localparam int DW   = 2 * W + 1;
    localparam int QW   = W + 1;
    localparam int CW   = DW + QW;

    // Saturate a sign and magnitude pair to W bits; top bit is the overflow flag
    function automatic logic [W:0] f_sat(input logic neg, input logic [SW-1:0] mag);
        logic [SW-1:0] lim;
        logic [SW-1:0] m;
        logic          ov;
        lim = neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
        ov  = (mag > lim);
        m   = ov ? lim : mag;
        return {ov, (neg ? W'(-m) : W'(m))};
    endfunction

    // Saturate an exact (W+1)-bit two's complement sum
    function automatic logic [W:0] f_sat_sum(input logic signed [W:0] v);
        logic ov;
        ov = (v[W] != v[W-1]);
        if (!ov) begin
            return {1'b0, v[W-1:0]};
        end else if (v[W]) begin
            return {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(W-1){1'b1}}};
        end
    endfunction

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------- stage 1: products and add/subtract ----------------
    t_ctl                  r1_ctl;
    logic signed [PW-1:0]  r1_prr, r1_pii, r1_pir, r1_pri, r1_pbb, r1_pcc;
    logic signed [W:0]     r1_sum_re, r1_sum_im;
    t_ctl                  n1_ctl;
    logic signed [W:0]     n1_sum_re, n1_sum_im;

    always_comb begin
        n1_ctl       = '0;
        n1_ctl.valid = accept;
        n1_ctl.op    = t_op'(i_req_type);
        if (t_op'(i_req_type) == OP_SUB) begin
            n1_sum_re = (W+1)'(i_a_real) - (W+1)'(i_b_real);
            n1_sum_im = (W+1)'(i_a_imag) - (W+1)'(i_b_imag);
        end else begin
            n1_sum_re = (W+1)'(i_a_real) + (W+1)'(i_b_real);
            n1_sum_im = (W+1)'(i_a_imag) + (W+1)'(i_b_imag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
        r1_prr    <= PW'(i_a_real) * PW'(i_b_real);
        r1_pii    <= PW'(i_a_imag) * PW'(i_b_imag);
        r1_pir    <= PW'(i_a_imag) * PW'(i_b_real);
        r1_pri    <= PW'(i_a_real) * PW'(i_b_imag);
        r1_pbb    <= PW'(i_b_real) * PW'(i_b_real);
        r1_pcc    <= PW'(i_b_imag) * PW'(i_b_imag);
        r1_sum_re <= n1_sum_re;
        r1_sum_im <= n1_sum_im;
    end

    // ---------------- stage 2: sums, rounding, divider setup ----------------
    logic signed [SW-1:0] s_re, s_im;
    logic [SW-1:0]        mag_re, mag_im, rm_re, rm_im;
    logic [DW-1:0]        den;
    logic [CW-1:0]        num_re, num_im, dvs;
    logic [W:0]           sat_re, sat_im;
    t_ctl                 n2_ctl;

    always_comb begin
        if (r1_ctl.op == OP_MUL) begin
            s_re = SW'(r1_prr) - SW'(r1_pii);
            s_im = SW'(r1_pir) + SW'(r1_pri);
        end else begin
            s_re = SW'(r1_prr) + SW'(r1_pii);
            s_im = SW'(r1_pir) - SW'(r1_pri);
        end
        mag_re = s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
        mag_im = s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
        rm_re  = (mag_re + (SW'(1) << (F - 1))) >> F;
        rm_im  = (mag_im + (SW'(1) << (F - 1))) >> F;
        den    = DW'($unsigned(r1_pbb)) + DW'($unsigned(r1_pcc));
        num_re = (CW'(mag_re) << (F + 1)) + CW'(den);
        num_im = (CW'(mag_im) << (F + 1)) + CW'(den);
        dvs    = CW'(den) << 1;

        if (r1_ctl.op == OP_MUL) begin
            sat_re = f_sat(s_re[SW-1], rm_re);
            sat_im = f_sat(s_im[SW-1], rm_im);
        end else begin
            sat_re = f_sat_sum(r1_sum_re);
            sat_im = f_sat_sum(r1_sum_im);
        end

        n2_ctl          = r1_ctl;
        n2_ctl.neg_re   = s_re[SW-1];
        n2_ctl.neg_im   = s_im[SW-1];
        n2_ctl.dz       = (r1_ctl.op == OP_DIV) && (den == '0);
        n2_ctl.pov_re   = (num_re >= (dvs << QW));
        n2_ctl.pov_im   = (num_im >= (dvs << QW));
        n2_ctl.ovf_pass = sat_re[W] || sat_im[W];
    end

    t_ctl          r2_ctl;
    logic [CW-1:0] r2_rem_re, r2_rem_im, r2_den;
    logic [W-1:0]  r2_pass_re, r2_pass_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= n2_ctl;
        end
        r2_rem_re  <= num_re;
        r2_rem_im  <= num_im;
        r2_den     <= dvs;
        r2_pass_re <= sat_re[W-1:0];
        r2_pass_im <= sat_im[W-1:0];
    end

    // ---------------- divider cell row ----------------
    t_ctl          l_ctl     [0:QW];
    logic [CW-1:0] l_rem_re  [0:QW];
    logic [CW-1:0] l_rem_im  [0:QW];
    logic [CW-1:0] l_den     [0:QW];
    logic [QW-1:0] l_q_re    [0:QW];
    logic [QW-1:0] l_q_im    [0:QW];
    logic [W-1:0]  l_pass_re [0:QW];
    logic [W-1:0]  l_pass_im [0:QW];

    assign l_ctl[0]     = r2_ctl;
    assign l_rem_re[0]  = r2_rem_re;
    assign l_rem_im[0]  = r2_rem_im;
    assign l_den[0]     = r2_den;
    assign l_q_re[0]    = '0;
    assign l_q_im[0]    = '0;
    assign l_pass_re[0] = r2_pass_re;
    assign l_pass_im[0] = r2_pass_im;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        cau_div_cell #(
            .W     (W),
            .CW    (CW),
            .QW    (QW),
            .SHIFT (QW - 1 - k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (l_ctl[k]),
            .i_rem_re  (l_rem_re[k]),
            .i_rem_im  (l_rem_im[k]),
            .i_den     (l_den[k]),
            .i_q_re    (l_q_re[k]),
            .i_q_im    (l_q_im[k]),
            .i_pass_re (l_pass_re[k]),
            .i_pass_im (l_pass_im[k]),
            .o_ctl     (l_ctl[k+1]),
            .o_rem_re  (l_rem_re[k+1]),
            .o_rem_im  (l_rem_im[k+1]),
            .o_den     (l_den[k+1]),
            .o_q_re    (l_q_re[k+1]),
            .o_q_im    (l_q_im[k+1]),
            .o_pass_re (l_pass_re[k+1]),
            .o_pass_im (l_pass_im[k+1])
        );
    end

    // ---------------- output stage ----------------
    t_ctl       f_ctl;
    logic [W:0] q_sat_re, q_sat_im;
    logic [W:0] lim_re, lim_im;
    logic [W-1:0] n_res_re, n_res_im;
    logic       n_ovf, n_dz;

    always_comb begin
        f_ctl    = l_ctl[QW];
        q_sat_re = f_sat(f_ctl.neg_re, SW'(l_q_re[QW]));
        q_sat_im = f_sat(f_ctl.neg_im, SW'(l_q_im[QW]));
        lim_re   = f_sat(f_ctl.neg_re, SW'(1) << W);
        lim_im   = f_sat(f_ctl.neg_im, SW'(1) << W);
        if (f_ctl.pov_re) begin
            q_sat_re = lim_re;
        end
        if (f_ctl.pov_im) begin
            q_sat_im = lim_im;
        end
        n_dz = 1'b0;
        if (f_ctl.op == OP_DIV) begin
            if (f_ctl.dz) begin
                n_res_re = '0;
                n_res_im = '0;
                n_ovf    = 1'b0;
                n_dz     = 1'b1;
            end else begin
                n_res_re = q_sat_re[W-1:0];
                n_res_im = q_sat_im[W-1:0];
                n_ovf    = q_sat_re[W] || q_sat_im[W];
            end
        end else begin
            n_res_re = l_pass_re[QW];
            n_res_im = l_pass_im[QW];
            n_ovf    = f_ctl.ovf_pass;
        end
    end

    logic r_strobe;
    logic [W-1:0] r_res_re, r_res_im;
    logic r_ovf, r_dz;

    // Register the result; hold the flags low on empty slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= f_ctl.valid;
        end
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_ovf    <= f_ctl.valid && n_ovf;
        r_dz     <= f_ctl.valid && n_dz;
    end

    assign o_strobe   = r_strobe;
    assign o_res_real = r_res_re;
    assign o_res_imag = r_res_im;
    assign o_overflow = r_ovf;
    assign o_div_zero = r_dz;

endmodule
`default_nettype wire

// ===== sv/cau_checker.sv =====
`default_nettype none
`include "complex_arith_unit_defines.svh"
module cau_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  o_strobe,
    input wire logic [DATA_WIDTH-1:0] o_res_real,
    input wire logic [DATA_WIDTH-1:0] o_res_imag,
    input wire logic                  o_overflow,
    input wire logic                  o_div_zero
);

    localparam int LATENCY = DATA_WIDTH + 4;

    // Every accepted beat comes out a fixed number of cycles later
    `CAU_ASSERT(a_latency, (start && !busy) |-> ##LATENCY o_strobe, "result missing after latency")

    // Zero divisor gives a clean zero result
    `CAU_ASSERT(a_dz_zero, (o_strobe && o_div_zero) |-> (o_res_real == '0 && o_res_imag == '0 && !o_overflow), "divide by zero result not zero")

    // Flags only count on a strobed beat
    `CAU_ASSERT(a_flags, (o_div_zero || o_overflow) |-> o_strobe, "flag raised without strobe")

    // No result leaves the cycle after a reset cycle
    `CAU_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_strobe, "strobe right after reset")

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_res_real (o_res_real),
    .o_res_imag (o_res_imag),
    .o_overflow (o_overflow),
    .o_div_zero (o_div_zero)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import cau_pkg::*;

    localparam int DW       = 32;
    localparam int FB       = 16;
    localparam int N_RANDOM = 800;
    localparam int LIMIT    = 200000;

    typedef logic signed [DW-1:0] t_word;

    typedef struct {
        t_word re;
        t_word im;
        logic  ovf;
        logic  dz;
    } t_cplx_res;

    // Predicts each complex result and holds the ones not yet returned
    class cplx_scoreboard;
        t_cplx_res pending_res[$];
        int        n_errors;
        int        n_checked;
        int        n_per_op[4];

        function new();
            n_errors  = 0;
            n_checked = 0;
            foreach (n_per_op[k]) n_per_op[k] = 0;
        endfunction

        // Round-free saturation of a sign-magnitude value to the word width
        static function t_word clamp(input logic sgn, input logic [127:0] mag,
                                     inout logic ovf);
            logic [127:0] lim;
            logic [127:0] m;
            lim = sgn ? (128'd1 << (DW - 1)) : ((128'd1 << (DW - 1)) - 1);
            m = mag;
            if (mag > lim) begin
                ovf = 1'b1;
                m = lim;
            end
            return sgn ? t_word'(-m) : t_word'(m);
        endfunction

        // Compute the expected result of one accepted beat
        function void note_beat(input t_op op, input t_word ar, input t_word ai,
                                input t_word br, input t_word bi);
            logic signed [127:0] xr, xi, yr, yi, vr, vi;
            logic [127:0]        den, mr, mi;
            logic                sr, si;
            t_cplx_res           res;
            xr = ar; xi = ai; yr = br; yi = bi;
            res.ovf = 1'b0;
            res.dz  = 1'b0;
            den = 128'(yr * yr + yi * yi);
            case (op)
                OP_ADD: begin vr = xr + yr; vi = xi + yi; end
                OP_SUB: begin vr = xr - yr; vi = xi - yi; end
                OP_MUL: begin vr = xr * yr - xi * yi; vi = xi * yr + xr * yi; end
                default: begin vr = xr * yr + xi * yi; vi = xi * yr - xr * yi; end
            endcase
            sr = vr < 0;
            si = vi < 0;
            mr = sr ? 128'(-vr) : 128'(vr);
            mi = si ? 128'(-vi) : 128'(vi);
            if (op == OP_MUL) begin
                // half away from zero on the magnitude
                mr = (mr + (128'd1 << (FB - 1))) >> FB;
                mi = (mi + (128'd1 << (FB - 1))) >> FB;
            end else if (op == OP_DIV && den != 0) begin
                mr = ((mr << (FB + 1)) + den) / (den << 1);
                mi = ((mi << (FB + 1)) + den) / (den << 1);
            end
            if (op == OP_DIV && den == 0) begin
                res.re = '0;
                res.im = '0;
                res.dz = 1'b1;
            end else begin
                res.re = clamp(sr, mr, res.ovf);
                res.im = clamp(si, mi, res.ovf);
            end
            n_per_op[op]++;
            pending_res.push_back(res);
        endfunction

        function void report(input string what);
            n_errors++;
            $display("[%0t] error: %s", $time, what);
        endfunction

        // Compare one returned result with the oldest prediction
        function void check_result(input t_word re, input t_word im,
                                   input logic ovf, input logic dz);
            t_cplx_res e;
            if (pending_res.size() == 0) begin
                report("result with no beat outstanding");
                return;
            end
            e = pending_res.pop_front();
            n_checked++;
            if (re !== e.re)
                report($sformatf("res_real %h, want %h", re, e.re));
            if (im !== e.im)
                report($sformatf("res_imag %h, want %h", im, e.im));
            if (ovf !== e.ovf)
                report($sformatf("overflow %b, want %b", ovf, e.ovf));
            if (dz !== e.dz)
                report($sformatf("div_zero %b, want %b", dz, e.dz));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    t_word       i_a_real = '0, i_a_imag = '0, i_b_real = '0, i_b_imag = '0;
    logic        o_strobe;
    t_word       o_res_real, o_res_imag;
    logic        o_overflow, o_div_zero;
    int          n_cycles = 0;

    cplx_scoreboard sb = new();

    complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag), .o_strobe(o_strobe),
        .o_res_real(o_res_real), .o_res_imag(o_res_imag),
        .o_overflow(o_overflow), .o_div_zero(o_div_zero)
    );

    always #10 i_clk = ~i_clk;

    // Accept a result at the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            sb.check_result(o_res_real, o_res_imag, o_overflow, o_div_zero);
    end

    // Bound the run
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one beat, hold it until taken, then idle a random gap
    task automatic send_op(input t_op op, input t_word ar, input t_word ai,
                           input t_word br, input t_word bi);
        int gap;
        gap = $urandom_range(0, 3);
        start      <= 1'b1;
        i_req_type <= op;
        i_a_real   <= ar;
        i_a_imag   <= ai;
        i_b_real   <= br;
        i_b_imag   <= bi;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_beat(op, ar, ai, br, bi);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_res.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_word pick_word();
        t_word v;
        case ($urandom_range(0, 4))
            0: v = t_word'($urandom);
            1: begin
                v = t_word'($urandom_range(0, 32'h0004_0000));
                if ($urandom_range(0, 1)) v = -v;
            end
            2: case ($urandom_range(0, 4))
                0: v = {1'b1, {(DW - 1){1'b0}}};
                1: v = {1'b0, {(DW - 1){1'b1}}};
                2: v = '0;
                3: v = 1;
                default: v = -1;
            endcase
            3: v = t_word'($urandom) >>> $urandom_range(0, 30);
            default: begin
                v = t_word'($urandom_range(0, 16)) <<< FB;
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    localparam t_word W_MAX  = {1'b0, {(DW - 1){1'b1}}};
    localparam t_word W_MIN  = {1'b1, {(DW - 1){1'b0}}};
    localparam t_word W_ONE  = t_word'(1) <<< FB;
    localparam t_word W_HALF = t_word'(1) <<< (FB - 1);

    initial begin
        t_op   op;
        t_word br, bi;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every opcode, rounding halves, zero divisor
        send_op(OP_ADD, W_MAX, W_MIN, W_MAX, W_MIN);
        send_op(OP_ADD, W_MAX, W_MIN, W_MIN, W_MAX);
        send_op(OP_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
        send_op(OP_SUB, 0, 0, W_MIN, W_MIN);
        send_op(OP_SUB, -1, 1, -1, 1);
        send_op(OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
        send_op(OP_MUL, W_MAX, W_MAX, W_MAX, W_MIN);
        send_op(OP_MUL, W_HALF, 0, 1, 0);
        send_op(OP_MUL, -W_HALF, 0, 1, 0);
        send_op(OP_MUL, W_ONE, W_ONE, W_ONE, -W_ONE);
        send_op(OP_MUL, 0, 0, 0, 0);
        send_op(OP_DIV, W_ONE, W_ONE, 0, 0);
        send_op(OP_DIV, W_MAX, W_MIN, 0, 0);
        send_op(OP_DIV, W_MAX, W_MIN, 1, 0);
        send_op(OP_DIV, W_MIN, W_MIN, 0, -1);
        send_op(OP_DIV, 1, 0, 2, 0);
        send_op(OP_DIV, -1, 0, 2, 0);
        send_op(OP_DIV, W_ONE, 0, 0, W_ONE);
        send_op(OP_DIV, W_MIN, W_MIN, W_MIN, W_MIN);
        send_op(OP_DIV, W_MAX, W_MAX, W_MAX, W_MIN);
        send_op(OP_DIV, 3 * W_ONE, -W_ONE, W_ONE, W_ONE);

        // Hold off until the pipeline is empty
        drain();

        // Random: mixed magnitudes, some zero divisors, random gaps between beats
        for (int n = 0; n < N_RANDOM; n++) begin
            op = t_op'($urandom_range(0, 3));
            br = pick_word();
            bi = pick_word();
            if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_op(op, pick_word(), pick_word(), br, bi);
            if (n == N_RANDOM / 2) drain();
        end

        drain();
        repeat (2 * DW + 10) @(posedge i_clk);
        $display("covered %0d results: %0d add, %0d sub, %0d mul, %0d div",
                 sb.n_checked, sb.n_per_op[OP_ADD], sb.n_per_op[OP_SUB],
                 sb.n_per_op[OP_MUL], sb.n_per_op[OP_DIV]);
        if (sb.n_errors == 0 && sb.pending_res.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results missing", sb.n_errors,
                     sb.pending_res.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
